[rtl/rccc_pkg.sv]
// Package with the shared types and constants of the resource credit cost curve.
package rccc_pkg;

   localparam int unsigned NumWidth  = 128;
   localparam int unsigned DenWidth  = 65;
   localparam int unsigned DivCells  = NumWidth;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_REGEN = 2'd1;
   localparam logic [1:0] ERR_DIV   = 2'd2;

   localparam logic [1:0] CSR_COEFF  = 2'd0;
   localparam logic [1:0] CSR_OFFSET = 2'd1;
   localparam logic [1:0] CSR_SHIFT  = 2'd2;

   typedef struct packed {
      logic                neg;
      logic                zero;
      logic [1:0]          err;
      logic [DenWidth-1:0] den;
   } side_type;

   typedef struct packed {
      side_type            side;
      logic [DenWidth-1:0] rem;
      logic [NumWidth-1:0] nq;
   } cell_type;

endpackage

[rtl/rccc_div_cell.sv]
// One restoring division step of the divider chain, registered.
module rccc_div_cell
   import rccc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  cell_type in_data,
   output logic     out_valid,
   output cell_type out_data
);

   logic             valid_ff;
   cell_type         data_ff;
   cell_type         data_in;
   logic [DenWidth:0] trial;
   logic [DenWidth:0] diff;
   logic             fits;

   always_comb begin
      trial = {in_data.rem, in_data.nq[NumWidth-1]};
      diff  = trial - {1'b0, in_data.side.den};
      fits  = trial >= {1'b0, in_data.side.den};
      data_in      = in_data;
      data_in.rem  = fits ? diff[DenWidth-1:0] : trial[DenWidth-1:0];
      data_in.nq   = {in_data.nq[NumWidth-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/resource_credit_cost_curve.sv]
// Top level of the resource credit cost curve: multiplier front end and divider chain.
//
//   Channel   Ports                                            Handshake
//   request   req_pool_level, req_request_count, req_regen_rate start && !busy
//   result    rsp_cost, rsp_error_code                         rsp_valid, one cycle
//   config    csr_index, csr_write_data                        csr_write_enable
//
// A new request is taken every cycle unless busy is high.
// Each result passes through six front stages for the two split multiplications,
// the 128-cell restoring divider chain and the output register.
// Reset is synchronous; busy is high during reset and in the first cycle after it.
// The receiver cannot stall, so nothing inside ever stops.
module resource_credit_cost_curve
   import rccc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_pool_level,
   input  logic [63:0] req_request_count,
   input  logic [63:0] req_regen_rate,
   output logic        rsp_valid,
   output logic [63:0] rsp_cost,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   logic [63:0] coeff_ff, offset_ff;
   logic [6:0]  shift_ff;
   logic        busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff  <= 64'd1;
         offset_ff <= 64'd1;
         shift_ff  <= 7'd0;
         busy_ff   <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_COEFF:  coeff_ff  <= csr_write_data;
               CSR_OFFSET: offset_ff <= csr_write_data;
               CSR_SHIFT:  shift_ff  <= csr_write_data[6:0];
               default:    ;
            endcase
         end
      end
   end

   assign busy = busy_ff;

   logic accept;
   assign accept = start && !busy_ff;

   // Stage 1: classify the request and form the divisor.
   logic [5:1]  v_ff;
   side_type    s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   side_type    s1_in;
   logic [63:0] regen1_ff, mag1_ff;
   logic [63:0] mag_in;
   logic        regen_bad;

   always_comb begin
      regen_bad   = (req_regen_rate == 64'd0) || req_regen_rate[63];
      s1_in.neg   = req_request_count[63];
      s1_in.zero  = (req_request_count == 64'd0);
      s1_in.den   = {1'b0, offset_ff}
                  + ((req_pool_level[63]) ? 65'd0 : {1'b0, req_pool_level});
      if (regen_bad) begin
         s1_in.err = ERR_REGEN;
      end else if (s1_in.zero) begin
         s1_in.err = ERR_OK;
      end else if (s1_in.den == '0) begin
         s1_in.err = ERR_DIV;
      end else begin
         s1_in.err = ERR_OK;
      end
      mag_in = req_request_count[63] ? (64'd0 - req_request_count) : req_request_count;
   end

   // Stage 2: partial products of regen and coefficient.
   logic [63:0] pa00_ff, pa01_ff, pa10_ff, pa11_ff;
   logic [63:0] mag2_ff, mag3_ff, mag4_ff;
   // Stage 3: full 128-bit product.
   logic [127:0] prod3_ff;
   // Stage 4: scaled rate.
   logic [127:0] rate4_ff;
   logic [127:0] rate4_in;
   // Stage 5: partial products of rate and magnitude.
   logic [63:0] pb00_ff, pb01_ff, pb10_ff, pb11_ff, pbh00_ff;
   logic [31:0] pbh01_ff, pbh10_ff;
   logic [63:0] hm1_tmp, hm2_tmp;
   // Stage 6: numerator into the divider chain.
   logic        v6_ff;
   cell_type    c0_ff;
   logic [127:0] num_in;

   assign rate4_in = (prod3_ff >> shift_ff) + 128'd1;
   assign hm1_tmp  = rate4_ff[95:64]  * mag4_ff[63:32];
   assign hm2_tmp  = rate4_ff[127:96] * mag4_ff[31:0];
   assign num_in   = {64'd0, pb00_ff}
                   + {32'd0, pb01_ff, 32'd0}
                   + {32'd0, pb10_ff, 32'd0}
                   + {pb11_ff, 64'd0}
                   + {pbh00_ff, 64'd0}
                   + {pbh01_ff, 96'd0}
                   + {pbh10_ff, 96'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         v6_ff <= 1'b0;
      end else begin
         v_ff  <= {v_ff[4:1], accept};
         v6_ff <= v_ff[5];
      end
      s1_ff     <= s1_in;
      regen1_ff <= req_regen_rate;
      mag1_ff   <= mag_in;

      pa00_ff <= regen1_ff[31:0]  * coeff_ff[31:0];
      pa01_ff <= regen1_ff[31:0]  * coeff_ff[63:32];
      pa10_ff <= regen1_ff[63:32] * coeff_ff[31:0];
      pa11_ff <= regen1_ff[63:32] * coeff_ff[63:32];
      mag2_ff <= mag1_ff;
      s2_ff   <= s1_ff;

      prod3_ff <= {64'd0, pa00_ff} + {32'd0, pa01_ff, 32'd0}
                + {32'd0, pa10_ff, 32'd0} + {pa11_ff, 64'd0};
      mag3_ff  <= mag2_ff;
      s3_ff    <= s2_ff;

      rate4_ff <= rate4_in;
      mag4_ff  <= mag3_ff;
      s4_ff    <= s3_ff;

      pb00_ff  <= rate4_ff[31:0]  * mag4_ff[31:0];
      pb01_ff  <= rate4_ff[31:0]  * mag4_ff[63:32];
      pb10_ff  <= rate4_ff[63:32] * mag4_ff[31:0];
      pb11_ff  <= rate4_ff[63:32] * mag4_ff[63:32];
      pbh00_ff <= rate4_ff[95:64] * mag4_ff[31:0];
      pbh01_ff <= hm1_tmp[31:0];
      pbh10_ff <= hm2_tmp[31:0];
      s5_ff    <= s4_ff;

      c0_ff.side <= s5_ff;
      c0_ff.rem  <= '0;
      c0_ff.nq   <= num_in;
   end

   logic     [DivCells:0] chain_valid;
   cell_type              chain_data [DivCells+1];

   assign chain_valid[0] = v6_ff;
   assign chain_data[0]  = c0_ff;

   for (genvar i = 0; i < DivCells; i++) begin : g_div
      rccc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   logic        rsp_valid_ff;
   logic [63:0] rsp_cost_ff, rsp_cost_in, quot;
   logic [1:0]  rsp_error_code_ff;
   cell_type    last;

   always_comb begin
      last = chain_data[DivCells];
      quot = last.nq[63:0] + 64'd1;
      if (last.side.err != ERR_OK || last.side.zero) begin
         rsp_cost_in = 64'd0;
      end else if (last.side.neg) begin
         rsp_cost_in = 64'd0 - quot;
      end else begin
         rsp_cost_in = quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain_valid[DivCells];
      end
      rsp_cost_ff       <= rsp_cost_in;
      rsp_error_code_ff <= last.side.err;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cost       = rsp_cost_ff;
   assign rsp_error_code = rsp_error_code_ff;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_OK) |-> rsp_cost == 64'd0)
      else $error("nonzero cost with error");
   a_code_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code == ERR_OK || rsp_error_code == ERR_REGEN
                     || rsp_error_code == ERR_DIV))
      else $error("illegal error code");

endmodule
